// ----- rtl/ect_pkg.sv -----
// Shared types and constants for the expression character tokenizer.
// Used by ect_lex and expression_char_tokenizer; no dependencies.
package ect_pkg;

	localparam int LINE_BITS = 20;
	localparam int COL_BITS  = 16;

	localparam int CH_BITS   = 8;
	localparam int OUT_BITS  = 4 + 1 + 1 + 1 + 1 + 2 + LINE_BITS + COL_BITS;
	localparam int OUT_TBITS = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [CH_BITS-1:0] CH_UNDER  = 8'h5F;
	localparam logic [CH_BITS-1:0] CH_DOT    = 8'h2E;
	localparam logic [CH_BITS-1:0] CH_QUOTE  = 8'h22;
	localparam logic [CH_BITS-1:0] CH_LF     = 8'h0A;
	localparam logic [CH_BITS-1:0] CH_TAB    = 8'h09;
	localparam logic [CH_BITS-1:0] CH_CR     = 8'h0D;
	localparam logic [CH_BITS-1:0] CH_SPACE  = 8'h20;
	localparam logic [CH_BITS-1:0] CH_PLUS   = 8'h2B;
	localparam logic [CH_BITS-1:0] CH_MINUS  = 8'h2D;
	localparam logic [CH_BITS-1:0] CH_STAR   = 8'h2A;
	localparam logic [CH_BITS-1:0] CH_SLASH  = 8'h2F;
	localparam logic [CH_BITS-1:0] CH_PCT    = 8'h25;
	localparam logic [CH_BITS-1:0] CH_EQUAL  = 8'h3D;
	localparam logic [CH_BITS-1:0] CH_LPAREN = 8'h28;
	localparam logic [CH_BITS-1:0] CH_RPAREN = 8'h29;
	localparam logic [CH_BITS-1:0] CH_0      = 8'h30;
	localparam logic [CH_BITS-1:0] CH_9      = 8'h39;
	localparam logic [CH_BITS-1:0] CH_LA     = 8'h61;
	localparam logic [CH_BITS-1:0] CH_LZ     = 8'h7A;
	localparam logic [CH_BITS-1:0] CH_UA     = 8'h41;
	localparam logic [CH_BITS-1:0] CH_UZ     = 8'h5A;

	typedef enum logic [3:0] {
		KIND_NONE   = 4'd0,
		KIND_IDENT  = 4'd1,
		KIND_NUMBER = 4'd2,
		KIND_STRING = 4'd3,
		KIND_PLUS   = 4'd4,
		KIND_MINUS  = 4'd5,
		KIND_MUL    = 4'd6,
		KIND_DIV    = 4'd7,
		KIND_MOD    = 4'd8,
		KIND_EQUAL  = 4'd9,
		KIND_LPAREN = 4'd10,
		KIND_RPAREN = 4'd11
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_UNRECOG  = 2'd1,
		ERR_OPEN_STR = 2'd2
	} err_t;

	typedef enum logic [4:0] {
		MODE_IDLE  = 5'b00001,
		MODE_IDENT = 5'b00010,
		MODE_INT   = 5'b00100,
		MODE_FRAC  = 5'b01000,
		MODE_STR   = 5'b10000
	} mode_t;

	typedef struct packed {
		kind_t kind;
		logic  starts_token;
		logic  in_text;
		logic  ends_previous;
		logic  ends_here;
		err_t  error;
	} lex_res_t;

endpackage

// ----- rtl/expression_char_tokenizer.sv -----
// Top level of the expression character tokenizer: input register, lexer step,
// line and column counters, result register. Depends on ect_pkg and ect_lex.
//
// Usage:
//   Slave stream takes one source character per item: tdata holds ch, tlast
//   marks the final character of the input. Master stream gives one result
//   item per character: kind, flags, error, line and column after it.
//   An item is taken on the slave side into the input register; the lexer
//   step runs on it and loads the result register once that register is
//   empty or being read, and the result is held there until the master
//   side takes it.
//   Throughput is one item per cycle while m_axis_tready is high: the mode
//   step and the counter update fit in the single stage between the registers.
//   When the master side stalls, the result register holds its item and the
//   input register still takes one more character; s_axis_tready drops only
//   when both registers are full and m_axis_tready is low.
//   Reset puts the lexer in idle mode, line count to one, column count to
//   zero, and empties both registers. tlast closes any open token but does
//   not clear the line and column counts.
module expression_char_tokenizer import ect_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [CH_BITS-1:0]   s_axis_tdata,  // [7:0] ch
	input  logic                 s_axis_tlast,  // last_char
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// [3:0] kind, [4] starts_token, [5] in_text, [6] ends_previous,
	// [7] ends_here, [9:8] error, [29:10] line_no, [45:30] col_no, rest zero
	output logic [OUT_TBITS-1:0] m_axis_tdata
);

	localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
	localparam logic [COL_BITS-1:0]  COL_MAX  = {COL_BITS{1'b1}};

	logic                 vld_s1;
	logic [CH_BITS-1:0]   ch_s1;
	logic                 last_s1;
	logic                 vld_s2;
	logic [OUT_BITS-1:0]  data_s2;
	logic                 adv;

	mode_t                mode_q;
	mode_t                mode_nxt;
	logic [LINE_BITS-1:0] line_q;
	logic [COL_BITS-1:0]  col_q;
	logic [LINE_BITS-1:0] line_nxt;
	logic [COL_BITS-1:0]  col_nxt;
	lex_res_t             res;

	ect_lex u_lex (
		.ch        (ch_s1),
		.last_char (last_s1),
		.mode      (mode_q),
		.res       (res),
		.mode_nxt  (mode_nxt)
	);

	assign adv           = vld_s1 && (!vld_s2 || m_axis_tready);
	assign s_axis_tready = !vld_s1 || adv;
	assign m_axis_tvalid = vld_s2;
	assign m_axis_tdata  = OUT_TBITS'(data_s2);

	always_comb begin
		line_nxt = line_q;
		col_nxt  = col_q;
		if (ch_s1 == CH_LF) begin
			col_nxt = '0;
			if (line_q != LINE_MAX)
				line_nxt = line_q + LINE_BITS'(1);
		end else if (col_q != COL_MAX) begin
			col_nxt = col_q + COL_BITS'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			mode_q <= MODE_IDLE;
			line_q <= LINE_BITS'(1);
			col_q  <= '0;
		end else begin
			if (s_axis_tready)
				vld_s1 <= s_axis_tvalid;
			if (adv)
				vld_s2 <= 1'b1;
			else if (m_axis_tready)
				vld_s2 <= 1'b0;
			if (adv) begin
				mode_q <= mode_nxt;
				line_q <= line_nxt;
				col_q  <= col_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			ch_s1   <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
		if (adv)
			data_s2 <= {col_nxt, line_nxt, res.error, res.ends_here, res.ends_previous,
				res.in_text, res.starts_token, res.kind};
	end

endmodule

// ----- rtl/ect_lex.sv -----
// Character classifier and lexer mode step for one character.
// Depends on ect_pkg for the mode, kind and result types.
module ect_lex import ect_pkg::*; (
	input  logic [CH_BITS-1:0] ch,
	input  logic               last_char,
	input  mode_t              mode,
	output lex_res_t           res,
	output mode_t              mode_nxt
);

	logic  is_alpha;
	logic  is_digit;
	logic  is_space;
	logic  is_quote;
	logic  handled;
	kind_t op_kind;

	assign is_alpha = (ch >= CH_LA && ch <= CH_LZ) || (ch >= CH_UA && ch <= CH_UZ) ||
		(ch == CH_UNDER);
	assign is_digit = (ch >= CH_0 && ch <= CH_9);
	assign is_space = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
	assign is_quote = (ch == CH_QUOTE);

	always_comb begin
		case (ch)
			CH_PLUS:   op_kind = KIND_PLUS;
			CH_MINUS:  op_kind = KIND_MINUS;
			CH_STAR:   op_kind = KIND_MUL;
			CH_SLASH:  op_kind = KIND_DIV;
			CH_PCT:    op_kind = KIND_MOD;
			CH_EQUAL:  op_kind = KIND_EQUAL;
			CH_LPAREN: op_kind = KIND_LPAREN;
			CH_RPAREN: op_kind = KIND_RPAREN;
			default:   op_kind = KIND_NONE;
		endcase
	end

	always_comb begin
		res      = '{kind: KIND_NONE, error: ERR_NONE, default: 1'b0};
		handled  = 1'b0;
		mode_nxt = mode;

		case (mode)
			MODE_STR: begin
				handled  = 1'b1;
				res.kind = KIND_STRING;
				if (is_quote) begin
					res.ends_here = 1'b1;
					mode_nxt      = MODE_IDLE;
				end else begin
					res.in_text = 1'b1;
					if (last_char) begin
						res.ends_here = 1'b1;
						res.error     = ERR_OPEN_STR;
						mode_nxt      = MODE_IDLE;
					end
				end
			end
			MODE_IDENT: begin
				if (is_alpha || is_digit) begin
					handled     = 1'b1;
					res.kind    = KIND_IDENT;
					res.in_text = 1'b1;
				end
			end
			MODE_INT: begin
				if (is_digit || ch == CH_DOT) begin
					handled     = 1'b1;
					res.kind    = KIND_NUMBER;
					res.in_text = 1'b1;
					if (ch == CH_DOT)
						mode_nxt = MODE_FRAC;
				end
			end
			MODE_FRAC: begin
				if (is_digit) begin
					handled     = 1'b1;
					res.kind    = KIND_NUMBER;
					res.in_text = 1'b1;
				end
			end
			default: begin
				mode_nxt = MODE_IDLE;
			end
		endcase

		if (!handled && mode != MODE_IDLE) begin
			res.ends_previous = 1'b1;
			mode_nxt          = MODE_IDLE;
		end

		if (handled) begin
			if (last_char && mode_nxt != MODE_IDLE) begin
				res.ends_here = 1'b1;
				mode_nxt      = MODE_IDLE;
			end
		end else if (is_space) begin
			res.kind = KIND_NONE;
		end else if (is_alpha || is_digit) begin
			res.kind         = is_digit ? KIND_NUMBER : KIND_IDENT;
			res.starts_token = 1'b1;
			res.in_text      = 1'b1;
			if (last_char)
				res.ends_here = 1'b1;
			else
				mode_nxt = is_digit ? MODE_INT : MODE_IDENT;
		end else if (is_quote) begin
			res.kind         = KIND_STRING;
			res.starts_token = 1'b1;
			if (last_char) begin
				res.ends_here = 1'b1;
				res.error     = ERR_OPEN_STR;
			end else begin
				mode_nxt = MODE_STR;
			end
		end else if (op_kind != KIND_NONE) begin
			res.kind         = op_kind;
			res.starts_token = 1'b1;
			res.in_text      = 1'b1;
			res.ends_here    = 1'b1;
		end else begin
			res.error = ERR_UNRECOG;
		end
	end

endmodule

// ----- dv/tb_expression_char_tokenizer.sv -----
`timescale 1ns / 1ps
// Self-checking bench for expression_char_tokenizer: character stream in, tag stream out.
// A small class predicts each tag from its own lexer state and checks results in order.
// Depends on ect_pkg and the RTL top level only.
module tb_expression_char_tokenizer;
	import ect_pkg::*;

	localparam logic [7:0] CH_VT = 8'h0B;
	localparam logic [7:0] CH_FF = 8'h0C;
	localparam int HOLD_CYCLES = 64;
	localparam int DRAIN_LIMIT = 100000;

	typedef struct {
		kind_t                kind;
		bit                   starts_token;
		bit                   in_text;
		bit                   ends_previous;
		bit                   ends_here;
		err_t                 error;
		logic [LINE_BITS-1:0] line_no;
		logic [COL_BITS-1:0]  col_no;
	} char_tag_t;

	class lexer_tag_tracker;
		mode_t                mode;
		logic [LINE_BITS-1:0] line_cnt;
		logic [COL_BITS-1:0]  col_cnt;
		char_tag_t            tags_due[$];
		int unsigned          fails;

		function new();
			mode = MODE_IDLE;
			line_cnt = LINE_BITS'(1);
			col_cnt = '0;
			fails = 0;
		endfunction

		function bit is_letter(logic [7:0] c);
			return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ) || c == CH_UNDER;
		endfunction

		function bit is_digit(logic [7:0] c);
			return c >= CH_0 && c <= CH_9;
		endfunction

		function bit is_blank(logic [7:0] c);
			return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
		endfunction

		function kind_t op_of(logic [7:0] c);
			case (c)
				CH_PLUS:   return KIND_PLUS;
				CH_MINUS:  return KIND_MINUS;
				CH_STAR:   return KIND_MUL;
				CH_SLASH:  return KIND_DIV;
				CH_PCT:    return KIND_MOD;
				CH_EQUAL:  return KIND_EQUAL;
				CH_LPAREN: return KIND_LPAREN;
				CH_RPAREN: return KIND_RPAREN;
				default:   return KIND_NONE;
			endcase
		endfunction

		function void note_char(logic [7:0] c, bit last);
			char_tag_t t;
			bit        taken;
			t.kind = KIND_NONE;
			t.starts_token = 0;
			t.in_text = 0;
			t.ends_previous = 0;
			t.ends_here = 0;
			t.error = ERR_NONE;
			taken = 0;
			case (mode)
				MODE_STR: begin
					taken = 1;
					t.kind = KIND_STRING;
					if (c == CH_QUOTE) begin
						t.ends_here = 1;
						mode = MODE_IDLE;
					end else begin
						t.in_text = 1;
						if (last) begin
							t.ends_here = 1;
							t.error = ERR_OPEN_STR;
							mode = MODE_IDLE;
						end
					end
				end
				MODE_IDENT: begin
					if (is_letter(c) || is_digit(c)) begin
						taken = 1;
						t.kind = KIND_IDENT;
						t.in_text = 1;
					end
				end
				MODE_INT: begin
					if (is_digit(c) || c == CH_DOT) begin
						taken = 1;
						t.kind = KIND_NUMBER;
						t.in_text = 1;
						if (c == CH_DOT)
							mode = MODE_FRAC;
					end
				end
				MODE_FRAC: begin
					if (is_digit(c)) begin
						taken = 1;
						t.kind = KIND_NUMBER;
						t.in_text = 1;
					end
				end
				default: mode = MODE_IDLE;
			endcase

			if (!taken && mode != MODE_IDLE) begin
				t.ends_previous = 1;
				mode = MODE_IDLE;
			end

			if (taken) begin
				if (last && mode != MODE_IDLE) begin
					t.ends_here = 1;
					mode = MODE_IDLE;
				end
			end else if (is_blank(c)) begin
			end else if (is_letter(c) || is_digit(c)) begin
				t.kind = is_digit(c) ? KIND_NUMBER : KIND_IDENT;
				t.starts_token = 1;
				t.in_text = 1;
				if (last)
					t.ends_here = 1;
				else
					mode = is_digit(c) ? MODE_INT : MODE_IDENT;
			end else if (c == CH_QUOTE) begin
				t.kind = KIND_STRING;
				t.starts_token = 1;
				if (last) begin
					t.ends_here = 1;
					t.error = ERR_OPEN_STR;
				end else begin
					mode = MODE_STR;
				end
			end else if (op_of(c) != KIND_NONE) begin
				t.kind = op_of(c);
				t.starts_token = 1;
				t.in_text = 1;
				t.ends_here = 1;
			end else begin
				t.error = ERR_UNRECOG;
			end

			// saturate both counters at all ones
			if (c == CH_LF) begin
				col_cnt = '0;
				if (line_cnt != '1)
					line_cnt = line_cnt + 1'b1;
			end else if (col_cnt != '1) begin
				col_cnt = col_cnt + 1'b1;
			end
			t.line_no = line_cnt;
			t.col_no = col_cnt;
			tags_due.push_back(t);
		endfunction

		function void cmp_field(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$display("%0t %s: expected %0d, actual %0d", $time, field, want, got);
				fails++;
			end
		endfunction

		function void check_tag(logic [OUT_TBITS-1:0] d);
			char_tag_t t;
			if (tags_due.size() == 0) begin
				$display("%0t unexpected item: expected none, actual %h", $time, d);
				fails++;
				return;
			end
			t = tags_due.pop_front();
			cmp_field("kind", 32'(t.kind), 32'(d[3:0]));
			cmp_field("starts_token", 32'(t.starts_token), 32'(d[4]));
			cmp_field("in_text", 32'(t.in_text), 32'(d[5]));
			cmp_field("ends_previous", 32'(t.ends_previous), 32'(d[6]));
			cmp_field("ends_here", 32'(t.ends_here), 32'(d[7]));
			cmp_field("error", 32'(t.error), 32'(d[9:8]));
			cmp_field("line_no", 32'(t.line_no), 32'(d[29:10]));
			cmp_field("col_no", 32'(t.col_no), 32'(d[45:30]));
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [CH_BITS-1:0]   s_axis_tdata;
	logic                 s_axis_tlast;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [OUT_TBITS-1:0] m_axis_tdata;

	lexer_tag_tracker tracker = new();

	int          idle_pct;
	int          stall_pct;
	bit          hold_req;
	int unsigned sent_count;
	logic [7:0]  text_q[$];
	logic [7:0]  op_chars[8] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH,
		CH_PCT, CH_EQUAL, CH_LPAREN, CH_RPAREN};
	logic [7:0]  blank_chars[6] = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
	int          phase_idle[4] = '{0, 69, 0, 19};
	int          phase_stall[4] = '{0, 0, 69, 19};

	expression_char_tokenizer u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("FAILURE");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			tracker.note_char(s_axis_tdata, s_axis_tlast);
		if (arst_n && m_axis_tvalid && m_axis_tready)
			tracker.check_tag(m_axis_tdata);
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		m_axis_tready = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_axis_tready <= 0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
				hold_req = 0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	function automatic logic [7:0] pick_letter();
		int r;
		r = $urandom_range(52);
		if (r < 26)
			return CH_LA + 8'(r);
		else if (r < 52)
			return CH_UA + 8'(r - 26);
		return CH_UNDER;
	endfunction

	function automatic logic [7:0] pick_digit();
		return CH_0 + 8'($urandom_range(9));
	endfunction

	task automatic send_char(input logic [7:0] c, input bit last);
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= c;
		s_axis_tlast <= last;
		do
			@(posedge clk);
		while (!s_axis_tready);
		sent_count++;
	endtask

	task automatic send_text(input string s, input bit last_on_end);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], last_on_end && i == s.len() - 1);
	endtask

	task automatic add_token();
		int         r;
		int         n;
		logic [7:0] c;
		r = $urandom_range(99);
		if (r < 22) begin
			text_q.push_back(pick_letter());
			n = $urandom_range(6);
			repeat (n)
				text_q.push_back(($urandom_range(3) == 0) ? pick_digit() : pick_letter());
		end else if (r < 40) begin
			n = $urandom_range(1, 4);
			repeat (n) text_q.push_back(pick_digit());
			if ($urandom_range(1)) begin
				text_q.push_back(CH_DOT);
				n = $urandom_range(3);
				repeat (n) text_q.push_back(pick_digit());
				if ($urandom_range(11) == 0) begin
					text_q.push_back(CH_DOT);
					text_q.push_back(pick_digit());
				end
			end
		end else if (r < 50) begin
			text_q.push_back(CH_QUOTE);
			n = $urandom_range(8);
			repeat (n) begin
				c = 8'($urandom_range(255));
				text_q.push_back((c == CH_QUOTE) ? CH_SPACE : c);
			end
			if ($urandom_range(6) != 0)
				text_q.push_back(CH_QUOTE);
		end else if (r < 75) begin
			text_q.push_back(op_chars[$urandom_range(7)]);
		end else if (r < 90) begin
			text_q.push_back(blank_chars[$urandom_range(5)]);
		end else begin
			text_q.push_back(8'($urandom_range(255)));
		end
	endtask

	// one expression ending in tlast, sometimes cut off mid-token
	task automatic send_expression();
		int n;
		text_q.delete();
		n = $urandom_range(1, 20);
		repeat (n) add_token();
		if ($urandom_range(6) == 0) begin
			n = $urandom_range(1, text_q.size());
			while (text_q.size() > n)
				void'(text_q.pop_back());
		end
		for (int i = 0; i < text_q.size(); i++)
			send_char(text_q[i], i == text_q.size() - 1);
	endtask

	initial begin
		int unsigned goal;
		int          waited;
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = 0;
		s_axis_tlast = 0;
		idle_pct = 0;
		stall_pct = 0;
		hold_req = 0;
		sent_count = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send_text("z_9A 0.5.+-*/%=()", 1'b0);
		send_char(8'h00, 1'b0);
		send_char(8'hFF, 1'b0);
		send_text("\t\n\"x", 1'b0);
		send_char(CH_UZ, 1'b1);
		send_char(CH_QUOTE, 1'b1);

		for (int p = 0; p < 4; p++) begin
			idle_pct = phase_idle[p];
			stall_pct = phase_stall[p];
			goal = sent_count + 340;
			if (p == 0)
				hold_req = 1;
			while (sent_count < goal) begin
				if ($urandom_range(9) == 0)
					repeat ($urandom_range(1, 8))
						send_char(8'($urandom_range(255)), $urandom_range(3) == 0);
				else
					send_expression();
			end
		end

		s_axis_tvalid <= 0;
		stall_pct = 0;
		waited = 0;
		while (tracker.tags_due.size() > 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
		if (tracker.fails == 0 && tracker.tags_due.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
